FILE: hw/rtl/tgal_pkg.sv
// ----------------------------------------------------------------------------
// tgal_pkg
// Shared types, constants and helpers for the touch drag axis-lock stepper.
// ----------------------------------------------------------------------------
package tgal_pkg;

  // Coordinate handling
  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned POS_W      = 10;            // port width of x/y
  localparam int unsigned SUM_W      = 13;            // saturating sums
  localparam int unsigned ACC_W      = 15;            // sum plus delta before clamp
  localparam int unsigned CNT_W      = 13;            // step_count width

  // Divider
  localparam int unsigned DVD_W      = 14;            // signed dividend
  localparam int unsigned MAG_W      = DVD_W - 1;     // dividend magnitude
  localparam int unsigned DVS_W      = 6;             // divisor
  localparam int unsigned REM_W      = DVS_W + 1;     // signed remainder
  localparam int unsigned DIV_CNT_W  = $clog2(MAG_W);
  localparam int unsigned DEG_PIXELS = 2;

  localparam int signed SUM_MAX = (1 << (SUM_W - 1)) - 1;
  localparam int signed SUM_MIN = -(1 << (SUM_W - 1));

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_DISTANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SAMPLES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MISSES  = 3'd4;

  localparam logic [5:0] PPS_RST     = 6'd3;
  localparam logic [7:0] DZ_RST      = 8'd12;
  localparam logic [7:0] FORCE_RST   = 8'd60;
  localparam logic [2:0] WARMUP_RST  = 3'd2;
  localparam logic [3:0] RELEASE_RST = 4'd3;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_XSTEP   = 3'd3,
    EV_YDEG    = 3'd4
  } tgal_event_e;

  typedef enum logic [1:0] {
    AX_NONE = 2'd0,
    AX_X    = 2'd1,
    AX_Y    = 2'd2
  } tgal_axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECIDE,
    ST_DIV,
    ST_EMIT
  } tgal_state_e;

  typedef struct packed {
    logic [5:0] pixels_per_step;
    logic [7:0] dead_zone;
    logic [7:0] force_distance;
    logic [2:0] warmup_samples;
    logic [3:0] release_misses;
  } tgal_cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [DVD_W-1:0] dividend;
    logic [DVS_W-1:0]        divisor;
  } tgal_div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DVD_W-1:0] quot;
    logic signed [REM_W-1:0] rem;
  } tgal_div_rsp_t;

  typedef struct packed {
    logic                    valid;
    tgal_event_e             ev;
    tgal_axis_e              axis;
    logic signed [CNT_W-1:0] count;
    logic                    active;
  } tgal_res_t;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > ACC_W'(SUM_MAX)) begin
      r = SUM_W'(SUM_MAX);
    end else if (v < ACC_W'(SUM_MIN)) begin
      r = SUM_W'(SUM_MIN);
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/touch_gesture_axis_lock_stepper_core.sv
// ----------------------------------------------------------------------------
// touch_gesture_axis_lock_stepper_core
// Touch drag to axis-locked X steps / Y degrees, one result per poll sample.
// ----------------------------------------------------------------------------
// Each accepted poll sample produces exactly one result. Samples that only
// track press, release, dropout or warm-up pass the evaluate and emit
// states; a counted motion sample that yields Y degrees, or leaves the axis
// undecided, also passes decide (degrees are a shift by one). An X step
// sample also waits in the divide state on the bit-serial divider that turns
// the summed motion into steps of pixels_per_step (one quotient bit per
// cycle). in_stall_o stays high until the result has moved into the output
// register, so a waiting result blocks the next sample only when that
// register is still full. The user must write configuration via a plain
// write port while no sample is in flight; the core does not check this.
module touch_gesture_axis_lock_stepper_core
  import tgal_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DAT_W-1:0]    cfg_data_i,
  // samples
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    touched_i,
  input  logic [POS_W-1:0]        x_pos_i,
  input  logic [POS_W-1:0]        y_pos_i,
  // results
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              event_res_o,
  output logic [1:0]              locked_axis_o,
  output logic signed [CNT_W-1:0] step_count_o,
  output logic                    gesture_active_o
);

  tgal_cfg_t     cfg_q, cfg_d;
  tgal_div_req_t div_req;
  tgal_div_rsp_t div_rsp;
  tgal_res_t     res;
  logic          res_take;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_ev_q;
  logic [1:0]    out_axis_q;
  logic signed [CNT_W-1:0] out_cnt_q;
  logic          out_active_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PIXELS_PER_STEP: cfg_d.pixels_per_step = cfg_data_i[5:0];
        CFG_DEAD_ZONE:       cfg_d.dead_zone       = cfg_data_i;
        CFG_FORCE_DISTANCE:  cfg_d.force_distance  = cfg_data_i;
        CFG_WARMUP_SAMPLES:  cfg_d.warmup_samples  = cfg_data_i[2:0];
        CFG_RELEASE_MISSES:  cfg_d.release_misses  = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixels_per_step <= PPS_RST;
      cfg_q.dead_zone       <= DZ_RST;
      cfg_q.force_distance  <= FORCE_RST;
      cfg_q.warmup_samples  <= WARMUP_RST;
      cfg_q.release_misses  <= RELEASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tgal_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .touched_i  (touched_i),
    .x_pos_i    (x_pos_i),
    .y_pos_i    (y_pos_i),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .res_o      (res),
    .res_take_i (res_take)
  );

  tgal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // output register
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res.valid && res_take) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_take) begin
      out_ev_q     <= res.ev;
      out_axis_q   <= res.axis;
      out_cnt_q    <= res.count;
      out_active_q <= res.active;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = out_ev_q;
  assign locked_axis_o    = out_axis_q;
  assign step_count_o     = out_cnt_q;
  assign gesture_active_o = out_active_q;

  // a sample in flight blocks the input on the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_XSTEP |-> locked_axis_o == AX_X)
    else $error("x steps without x lock");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_YDEG |-> locked_axis_o == AX_Y)
    else $error("y degrees without y lock");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gesture_active_o |-> locked_axis_o == AX_NONE)
    else $error("axis locked outside a gesture");

endmodule

FILE: hw/rtl/tgal_div.sv
// ----------------------------------------------------------------------------
// tgal_div
// Bit-serial restoring divider, truncating toward zero, signed remainder.
// ----------------------------------------------------------------------------
module tgal_div
  import tgal_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tgal_div_req_t req_i,
  output tgal_div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;

  logic [MAG_W-1:0]     mag;
  logic [DVS_W:0]       shifted;
  logic [DVS_W+1:0]     trial;

  // work on the magnitude, restore the sign at the end
  assign mag     = req_i.dividend[DVD_W-1] ? MAG_W'(-req_i.dividend)
                                           : req_i.dividend[MAG_W-1:0];
  assign shifted = {rem_q, quo_q[MAG_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.dividend[DVD_W-1];
      cnt_d  = DIV_CNT_W'(MAG_W - 1);
      quo_d  = mag;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[DVS_W+1]) begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVS_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      neg_q  <= neg_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign rsp_o.rem  = neg_q ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});

endmodule

FILE: hw/rtl/tgal_seq.sv
// ----------------------------------------------------------------------------
// tgal_seq
// Gesture state and sequencer: press/release tracking, sums, axis decision.
// ----------------------------------------------------------------------------
module tgal_seq
  import tgal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tgal_cfg_t         cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              touched_i,
  input  logic [POS_W-1:0]  x_pos_i,
  input  logic [POS_W-1:0]  y_pos_i,
  output tgal_div_req_t     div_req_o,
  input  tgal_div_rsp_t     div_rsp_i,
  output tgal_res_t         res_o,
  input  logic              res_take_i
);

  tgal_state_e state_q, state_d;

  // sample
  logic                  touched_q;
  logic [COORD_BITS-1:0] x_q, y_q;

  // gesture state
  logic                    prev_down_q, prev_down_d;
  logic [3:0]              miss_q, miss_d;
  logic                    gesture_q, gesture_d;
  tgal_axis_e              axis_q, axis_d;
  logic [2:0]              warm_q, warm_d;
  logic [COORD_BITS-1:0]   anchor_x_q, anchor_x_d, anchor_y_q, anchor_y_d;
  logic signed [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic signed [REM_W-1:0] step_rest_q, step_rest_d;
  logic signed [1:0]       deg_rest_q, deg_rest_d;
  tgal_event_e             ev_q, ev_d;
  logic signed [CNT_W-1:0] cnt_q, cnt_d;

  logic                    accept;
  logic signed [COORD_BITS:0] dx, dy;
  logic signed [SUM_W-1:0] sum_x_new, sum_y_new;
  logic [3:0]              miss_inc;
  logic [SUM_W-1:0]        abs_x, abs_y;
  logic [SUM_W:0]          tot, dbl_x, dbl_y;
  logic                    apply;
  tgal_axis_e              axis_new;
  logic [DVS_W-1:0]        per;
  logic signed [DVD_W-1:0] deg_sum, deg_adj, deg_quo;
  logic signed [1:0]       deg_rem_new;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  assign dx = $signed({1'b0, x_q}) - $signed({1'b0, anchor_x_q});
  assign dy = $signed({1'b0, y_q}) - $signed({1'b0, anchor_y_q});
  assign sum_x_new = sat_sum(ACC_W'(sum_x_q) + ACC_W'(dx));
  assign sum_y_new = sat_sum(ACC_W'(sum_y_q) + ACC_W'(dy));
  assign miss_inc  = miss_q + 4'd1;

  // axis decision on the stored sums
  assign abs_x = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : sum_x_q;
  assign abs_y = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : sum_y_q;
  assign tot   = {1'b0, abs_x} + {1'b0, abs_y};
  assign dbl_x = {abs_x, 1'b0};
  assign dbl_y = {abs_y, 1'b0};
  assign per   = (cfg_i.pixels_per_step == '0) ? DVS_W'(1) : cfg_i.pixels_per_step;

  // degrees are 2 px each: halve with a shift, pulling negative sums toward zero
  assign deg_sum     = DVD_W'(deg_rest_q) + DVD_W'(sum_y_q);
  assign deg_adj     = deg_sum + $signed({{(DVD_W-1){1'b0}}, deg_sum[DVD_W-1]});
  assign deg_quo     = deg_adj >>> 1;
  assign deg_rem_new = deg_sum[0] ? (deg_sum[DVD_W-1] ? 2'sb11 : 2'sb01) : 2'sb00;

  always_comb begin
    apply    = 1'b1;
    axis_new = axis_q;
    if (axis_q == AX_NONE) begin
      priority if (tot < (SUM_W+1)'(cfg_i.dead_zone)) begin
        apply = 1'b0;
      end else if ({1'b0, abs_x} > dbl_y) begin
        axis_new = AX_X;
      end else if ({1'b0, abs_y} > dbl_x) begin
        axis_new = AX_Y;
      end else if (tot >= (SUM_W+1)'(cfg_i.force_distance)) begin
        axis_new = (abs_x >= abs_y) ? AX_X : AX_Y;
      end else begin
        apply = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (touched_q && prev_down_q && miss_q == '0 && gesture_q && warm_q == '0) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DECIDE: begin
        state_d = (apply && axis_new == AX_X) ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (div_rsp_i.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates and outputs
  always_comb begin
    prev_down_d = prev_down_q;
    miss_d      = miss_q;
    gesture_d   = gesture_q;
    axis_d      = axis_q;
    warm_d      = warm_q;
    anchor_x_d  = anchor_x_q;
    anchor_y_d  = anchor_y_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    step_rest_d = step_rest_q;
    deg_rest_d  = deg_rest_q;
    ev_d        = ev_q;
    cnt_d       = cnt_q;

    div_req_o.start    = 1'b0;
    div_req_o.dividend = DVD_W'(step_rest_q) + DVD_W'(sum_x_q);
    div_req_o.divisor  = per;

    unique case (state_q)
      ST_EVAL: begin
        ev_d  = EV_NONE;
        cnt_d = '0;
        if (touched_q) begin
          prev_down_d = 1'b1;
          miss_d      = '0;
          if (!prev_down_q) begin
            gesture_d   = 1'b1;
            axis_d      = AX_NONE;
            sum_x_d     = '0;
            sum_y_d     = '0;
            step_rest_d = '0;
            deg_rest_d  = '0;
            warm_d      = cfg_i.warmup_samples;
            anchor_x_d  = x_q;
            anchor_y_d  = y_q;
            ev_d        = EV_PRESS;
          end else if (miss_q != '0) begin
            // dropout recovery: re-anchor only
            if (gesture_q) begin
              anchor_x_d = x_q;
              anchor_y_d = y_q;
            end
          end else if (gesture_q) begin
            anchor_x_d = x_q;
            anchor_y_d = y_q;
            if (warm_q != '0) begin
              warm_d = warm_q - 3'd1;
            end else begin
              sum_x_d = sum_x_new;
              sum_y_d = sum_y_new;
            end
          end
        end else if (prev_down_q) begin
          miss_d = miss_inc;
          if (miss_inc >= cfg_i.release_misses || miss_inc == '0) begin
            gesture_d   = 1'b0;
            axis_d      = AX_NONE;
            prev_down_d = 1'b0;
            miss_d      = '0;
            ev_d        = EV_RELEASE;
          end
        end
      end
      ST_DECIDE: begin
        if (apply) begin
          axis_d  = axis_new;
          sum_x_d = '0;
          sum_y_d = '0;
          if (axis_new == AX_X) begin
            div_req_o.start = 1'b1;
          end else begin
            cnt_d      = deg_quo[CNT_W-1:0];
            deg_rest_d = deg_rem_new;
            ev_d       = EV_YDEG;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          cnt_d       = div_rsp_i.quot[CNT_W-1:0];
          step_rest_d = div_rsp_i.rem;
          ev_d        = EV_XSTEP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_down_q <= 1'b0;
      miss_q      <= '0;
      gesture_q   <= 1'b0;
      axis_q      <= AX_NONE;
      warm_q      <= '0;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      step_rest_q <= '0;
      deg_rest_q  <= '0;
    end else begin
      state_q     <= state_d;
      prev_down_q <= prev_down_d;
      miss_q      <= miss_d;
      gesture_q   <= gesture_d;
      axis_q      <= axis_d;
      warm_q      <= warm_d;
      anchor_x_q  <= anchor_x_d;
      anchor_y_q  <= anchor_y_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      step_rest_q <= step_rest_d;
      deg_rest_q  <= deg_rest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q  <= ev_d;
    cnt_q <= cnt_d;
    if (accept) begin
      touched_q <= touched_i;
      x_q       <= COORD_BITS'(x_pos_i);
      y_q       <= COORD_BITS'(y_pos_i);
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign res_o.valid  = (state_q == ST_EMIT);
  assign res_o.ev     = ev_q;
  assign res_o.axis   = axis_q;
  assign res_o.count  = cnt_q;
  assign res_o.active = gesture_q;

endmodule

FILE: verif/touch_gesture_axis_lock_stepper_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_axis_lock_stepper_core_tb
// Self-checking bench: a short directed table of touch polls, then random
// drag gestures under several register settings. Every poll is predicted in
// the bench and each result is compared field by field against the
// oldest expected result, or the fixed value of a directed row.
// ----------------------------------------------------------------------------
module touch_gesture_axis_lock_stepper_core_tb;
  import tgal_pkg::*;

  typedef struct {
    tgal_event_e             ev;
    tgal_axis_e              axis;
    logic signed [CNT_W-1:0] cnt;
    logic                    active;
  } poll_result_t;

  typedef struct {
    logic             touched;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    bit               fixed;
    poll_result_t     res;
  } poll_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DAT_W-1:0]    cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    touched_i;
  logic [POS_W-1:0]        x_pos_i;
  logic [POS_W-1:0]        y_pos_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [2:0]              event_res_o;
  logic [1:0]              locked_axis_o;
  logic signed [CNT_W-1:0] step_count_o;
  logic                    gesture_active_o;

  touch_gesture_axis_lock_stepper_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .touched_i       (touched_i),
    .x_pos_i         (x_pos_i),
    .y_pos_i         (y_pos_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_o     (event_res_o),
    .locked_axis_o   (locked_axis_o),
    .step_count_o    (step_count_o),
    .gesture_active_o(gesture_active_o)
  );

  // register shadow
  logic [5:0] cfg_pps;
  logic [7:0] cfg_dz;
  logic [7:0] cfg_force;
  logic [2:0] cfg_warm;
  logic [3:0] cfg_rel;

  // gesture shadow
  logic                    prev_touch;
  logic                    gest_on;
  logic [3:0]              miss_cnt;
  tgal_axis_e              lock_axis;
  logic [2:0]              warm_cnt;
  logic [POS_W-1:0]        anc_x;
  logic [POS_W-1:0]        anc_y;
  logic signed [SUM_W-1:0] acc_x;
  logic signed [SUM_W-1:0] acc_y;
  logic signed [6:0]       step_rem;
  logic signed [1:0]       deg_rem;

  poll_result_t poll_results_q[$];
  poll_row_t    directed_rows[$];
  poll_result_t seen_exp;
  int           polls_sent;
  int           mismatch_cnt;
  int           snd_idle_pct;
  int           rcv_idle_pct;
  int           stall_left;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [SUM_W-1:0] clamp_sum(input int v);
    if (v > 4095) return 13'sd4095;
    if (v < -4096) return -13'sd4096;
    return v[SUM_W-1:0];
  endfunction

  function automatic poll_result_t predict_poll(input logic t, input logic [POS_W-1:0] xp,
                                                input logic [POS_W-1:0] yp);
    poll_result_t r;
    int x, y, ax, ay, tot, per, v, q;
    bit apply;
    x = int'(xp) & ((1 << COORD_BITS) - 1);
    y = int'(yp) & ((1 << COORD_BITS) - 1);
    r.ev = EV_NONE;
    q = 0;
    if (t) begin
      if (!prev_touch) begin
        gest_on   = 1'b1;
        lock_axis = AX_NONE;
        acc_x     = '0;
        acc_y     = '0;
        step_rem  = '0;
        deg_rem   = '0;
        warm_cnt  = cfg_warm;
        anc_x     = x[POS_W-1:0];
        anc_y     = y[POS_W-1:0];
        r.ev      = EV_PRESS;
      end else if (miss_cnt != 0) begin
        // dropout recovery: re-anchor only
        if (gest_on) begin
          anc_x = x[POS_W-1:0];
          anc_y = y[POS_W-1:0];
        end
      end else if (gest_on) begin
        if (warm_cnt != 0) begin
          warm_cnt = warm_cnt - 3'd1;
          anc_x    = x[POS_W-1:0];
          anc_y    = y[POS_W-1:0];
        end else begin
          apply = 1'b1;
          acc_x = clamp_sum(int'(acc_x) + x - int'(anc_x));
          acc_y = clamp_sum(int'(acc_y) + y - int'(anc_y));
          anc_x = x[POS_W-1:0];
          anc_y = y[POS_W-1:0];
          if (lock_axis == AX_NONE) begin
            ax  = (acc_x < 0) ? -int'(acc_x) : int'(acc_x);
            ay  = (acc_y < 0) ? -int'(acc_y) : int'(acc_y);
            tot = ax + ay;
            if (tot < int'(cfg_dz)) apply = 1'b0;
            else if (ax > 2 * ay) lock_axis = AX_X;
            else if (ay > 2 * ax) lock_axis = AX_Y;
            else if (tot >= int'(cfg_force)) lock_axis = (ax >= ay) ? AX_X : AX_Y;
            else apply = 1'b0;
          end
          if (apply) begin
            if (lock_axis == AX_X) begin
              per      = (cfg_pps == 0) ? 1 : int'(cfg_pps);
              v        = int'(step_rem) + int'(acc_x);
              q        = v / per;
              step_rem = 7'(v - q * per);
              r.ev     = EV_XSTEP;
            end else begin
              v       = int'(deg_rem) + int'(acc_y);
              q       = v / int'(DEG_PIXELS);
              deg_rem = 2'(v - q * int'(DEG_PIXELS));
              r.ev    = EV_YDEG;
            end
            acc_x = '0;
            acc_y = '0;
          end
        end
      end
      miss_cnt   = '0;
      prev_touch = 1'b1;
    end else if (prev_touch) begin
      miss_cnt = miss_cnt + 4'd1;
      // a zero release count wraps around to an immediate release
      if (miss_cnt >= cfg_rel || miss_cnt == 0) begin
        gest_on    = 1'b0;
        lock_axis  = AX_NONE;
        prev_touch = 1'b0;
        miss_cnt   = '0;
        r.ev       = EV_RELEASE;
      end
    end
    r.axis   = lock_axis;
    r.cnt    = q[CNT_W-1:0];
    r.active = gest_on;
    return r;
  endfunction

  task automatic compare_field(input string name, input integer want, input integer got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (poll_results_q.size() == 0) begin
        $display("%0t: unexpected result, event_res %0d", $time, event_res_o);
        mismatch_cnt++;
      end else begin
        seen_exp = poll_results_q.pop_front();
        compare_field("event_res", 32'(seen_exp.ev), 32'(event_res_o));
        compare_field("locked_axis", 32'(seen_exp.axis), 32'(locked_axis_o));
        compare_field("step_count", 32'(seen_exp.cnt), 32'(step_count_o));
        compare_field("gesture_active", 32'(seen_exp.active), 32'(gesture_active_o));
      end
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 99) < rcv_idle_pct) begin
      stall_left = $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_poll(input logic t, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input bit fixed = 1'b0,
                           input poll_result_t fixed_res = '{EV_NONE, AX_NONE, '0, 1'b0});
    poll_result_t r;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    touched_i  <= t;
    x_pos_i    <= x;
    y_pos_i    <= y;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_poll(t, x, y);
    poll_results_q.push_back(fixed ? fixed_res : r);
    polls_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    case (idx)
      CFG_PIXELS_PER_STEP: cfg_pps   = d[5:0];
      CFG_DEAD_ZONE:       cfg_dz    = d;
      CFG_FORCE_DISTANCE:  cfg_force = d;
      CFG_WARMUP_SAMPLES:  cfg_warm  = d[2:0];
      CFG_RELEASE_MISSES:  cfg_rel   = d[3:0];
      default: ;
    endcase
  endtask

  // sender pauses until every outstanding request has returned
  task automatic drain_and_setup(input logic [7:0] pps, input logic [7:0] dz,
                                 input logic [7:0] frc, input logic [7:0] warm,
                                 input logic [7:0] rel);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (poll_results_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    write_reg(CFG_PIXELS_PER_STEP, pps);
    write_reg(CFG_DEAD_ZONE, dz);
    write_reg(CFG_FORCE_DISTANCE, frc);
    write_reg(CFG_WARMUP_SAMPLES, warm);
    write_reg(CFG_RELEASE_MISSES, rel);
    cfg_we_i <= 1'b0;
    snd_idle_pct = $urandom_range(0, 2) * 10;
    rcv_idle_pct = $urandom_range(0, 2) * 10;
  endtask

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic run_gesture();
    int cx, cy, dx, dy, bias, m, misses;
    repeat ($urandom_range(0, 2))
      send_poll(1'b0, POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)));
    cx = $urandom_range(0, 1023);
    cy = $urandom_range(0, 1023);
    send_poll(1'b1, POS_W'(cx), POS_W'(cy));
    repeat (int'(cfg_warm) + $urandom_range(0, 1))
      send_poll(1'b1, POS_W'(clamp_coord(cx + jitter(3))),
                POS_W'(clamp_coord(cy + jitter(3))));
    bias = $urandom_range(0, 2);
    repeat ($urandom_range(1, 16)) begin
      if ($urandom_range(0, 11) == 0) begin
        misses = (cfg_rel > 1) ? $urandom_range(1, cfg_rel - 1) : 1;
        repeat (misses)
          send_poll(1'b0, POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)));
      end
      m = $urandom_range(0, 9);
      if (m < 6) begin
        dx = jitter(8);
        dy = jitter(8);
      end else if (m < 9) begin
        dx = jitter(40);
        dy = jitter(40);
      end else begin
        dx = int'($urandom_range(0, 1023)) - cx;
        dy = int'($urandom_range(0, 1023)) - cy;
      end
      if (bias == 0) dy = dy / 4;
      else if (bias == 1) dx = dx / 4;
      cx = clamp_coord(cx + dx);
      cy = clamp_coord(cy + dy);
      send_poll(1'b1, POS_W'(cx), POS_W'(cy));
    end
    misses = (cfg_rel == 0) ? 1 : int'(cfg_rel);
    repeat (misses + $urandom_range(0, 2))
      send_poll(1'b0, POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)));
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = polls_sent + n;
    while (polls_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        send_poll(1'($urandom_range(0, 1)), POS_W'($urandom_range(0, 1023)),
                  POS_W'($urandom_range(0, 1023)));
      else
        run_gesture();
    end
  endtask

  task automatic add_row(input logic t, input int x, input int y, input bit fixed,
                         input tgal_event_e ev = EV_NONE, input tgal_axis_e ax = AX_NONE,
                         input int cnt = 0, input logic act = 1'b0);
    poll_row_t row;
    row.touched    = t;
    row.x          = x[POS_W-1:0];
    row.y          = y[POS_W-1:0];
    row.fixed      = fixed;
    row.res.ev     = ev;
    row.res.axis   = ax;
    row.res.cnt    = cnt[CNT_W-1:0];
    row.res.active = act;
    directed_rows.push_back(row);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_PIXELS_PER_STEP;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    touched_i    <= 1'b0;
    x_pos_i      <= '0;
    y_pos_i      <= '0;
    out_stall_i  <= 1'b0;
    stall_left   = 0;
    polls_sent   = 0;
    mismatch_cnt = 0;
    snd_idle_pct = 15;
    rcv_idle_pct = 15;
    cfg_pps = PPS_RST;   cfg_dz   = DZ_RST;      cfg_force = FORCE_RST;
    cfg_warm = WARMUP_RST; cfg_rel = RELEASE_RST;
    prev_touch = 1'b0; gest_on = 1'b0; miss_cnt = '0; lock_axis = AX_NONE;
    warm_cnt = '0; anc_x = '0; anc_y = '0; acc_x = '0; acc_y = '0;
    step_rem = '0; deg_rem = '0;

    // directed table, reset register values
    add_row(1'b0, 0, 0, 1'b1, EV_NONE, AX_NONE, 0, 1'b0);        // untouched while idle
    add_row(1'b1, 1023, 1023, 1'b1, EV_PRESS, AX_NONE, 0, 1'b1);
    add_row(1'b1, 0, 0, 1'b1, EV_NONE, AX_NONE, 0, 1'b1);        // warm-up
    add_row(1'b1, 512, 512, 1'b1, EV_NONE, AX_NONE, 0, 1'b1);    // warm-up
    add_row(1'b1, 542, 512, 1'b1, EV_XSTEP, AX_X, 10, 1'b1);     // X lock
    add_row(1'b1, 543, 517, 1'b1, EV_XSTEP, AX_X, 0, 1'b1);      // zero-step event
    add_row(1'b0, 0, 0, 1'b1, EV_NONE, AX_X, 0, 1'b1);           // one miss
    add_row(1'b1, 0, 1023, 1'b1, EV_NONE, AX_X, 0, 1'b1);        // re-anchor
    add_row(1'b1, 1023, 0, 1'b0);                                // full-scale moves
    add_row(1'b1, 0, 0, 1'b0);
    add_row(1'b0, 0, 0, 1'b0);
    add_row(1'b0, 1023, 1023, 1'b0);
    add_row(1'b0, 0, 0, 1'b1, EV_RELEASE, AX_NONE, 0, 1'b0);
    add_row(1'b1, 100, 100, 1'b1, EV_PRESS, AX_NONE, 0, 1'b1);
    add_row(1'b1, 100, 100, 1'b0);
    add_row(1'b1, 100, 100, 1'b0);
    add_row(1'b1, 102, 120, 1'b1, EV_YDEG, AX_Y, 10, 1'b1);      // Y lock
    add_row(1'b1, 102, 125, 1'b0);
    add_row(1'b1, 102, 118, 1'b0);
    add_row(1'b0, 0, 0, 1'b0);
    add_row(1'b0, 0, 0, 1'b0);
    add_row(1'b0, 0, 0, 1'b1, EV_RELEASE, AX_NONE, 0, 1'b0);
    add_row(1'b1, 200, 200, 1'b1, EV_PRESS, AX_NONE, 0, 1'b1);
    add_row(1'b1, 200, 200, 1'b0);
    add_row(1'b1, 200, 200, 1'b0);
    add_row(1'b1, 210, 210, 1'b1, EV_NONE, AX_NONE, 0, 1'b1);    // ambiguous, below force
    add_row(1'b1, 240, 240, 1'b0);                               // forced, tie picks X

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_poll(directed_rows[i].touched, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].fixed, directed_rows[i].res);
    run_random(120);

    drain_and_setup(8'd1, 8'd0, 8'd0, 8'd0, 8'd1);
    run_random(130);
    drain_and_setup(8'd63, 8'd255, 8'd255, 8'd7, 8'd15);
    run_random(130);
    drain_and_setup(8'd0, 8'd5, 8'd30, 8'd1, 8'd0);
    run_random(130);
    drain_and_setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
    run_random(130);
    drain_and_setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)),
                    8'($urandom_range(0, 120)), 8'($urandom_range(0, 7)),
                    8'($urandom_range(1, 15)));
    run_random(130);
    // closing stretch runs at full rate on both sides
    drain_and_setup(8'd5, 8'd12, 8'd60, 8'd2, 8'd3);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(100);

    in_valid_i <= 1'b0;
    while (poll_results_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
